// File: rtl/cde_pkg.sv
// Shared types, constants and helper functions for the carrier density evaluator.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
package cde_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FD_TERMS_DEF  = 16;

  // divider chain: byte-wide cells, remainder width covers divisors up to 31
  localparam int DIV_W     = 5;
  localparam int DIV_CELLS = 8;

  localparam int EXP_TERMS = 13;

  localparam logic [28:0]        EINV_Q30  = 29'd395007542;
  localparam logic signed [31:0] R_E_LIMIT = 32'sd15099494;
  localparam logic signed [31:0] R_H_LIMIT = 32'sd16777216;
  localparam logic signed [63:0] ONE_Q30   = 64'sd1073741824;
  localparam logic [62:0]        MAG_MAX   = '1;

  localparam logic signed [63:0] ETA_Q30 [17] = '{
    64'sd821570600, 64'sd649504973, 64'sd408134435, 64'sd127432615, -64'sd94318685,
    -64'sd103130330, 64'sd146910762, 64'sd256754563, -64'sd530934559,
    -64'sd1267283472, 64'sd3428600796, 64'sd10367691797, -64'sd34651230177,
    -64'sd126842758486, 64'sd504690933935, 64'sd2168749011252,
    -64'sd10009845832411
  };

  typedef enum logic [1:0] {
    CFG_INV   = 2'd0,
    CFG_DOS_E = 2'd1,
    CFG_DOS_H = 2'd2,
    CFG_TOL   = 2'd3
  } cfg_idx_e;

  typedef enum logic [4:0] {
    ST_IDLE, ST_R_GO, ST_R_WAIT,
    ST_EM_GO, ST_EM_WAIT, ST_ED_GO, ST_ED_WAIT, ST_EPOW,
    ST_PP_GO, ST_PP_WAIT, ST_PT_GO, ST_PT_WAIT, ST_PB_GO, ST_PB_WAIT,
    ST_FM_GO, ST_FM_WAIT, ST_FD_GO, ST_FD_WAIT, ST_FT_GO, ST_FT_WAIT,
    ST_FB_GO, ST_FB_WAIT,
    ST_SD_GO, ST_SD_WAIT, ST_DOS_GO, ST_DOS_WAIT, ST_DONE
  } state_e;

  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic             start;
    logic [63:0]      dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  // elaboration-time integer square root (weight tables)
  function automatic logic [63:0] isqrt64(logic [63:0] v);
    logic [63:0] vv;
    logic [63:0] rr;
    logic [63:0] bb;
    vv = v;
    rr = '0;
    bb = 64'h4000_0000_0000_0000;
    for (int j = 0; j < 32; j++) begin
      if (bb > vv) bb = bb >> 2;
    end
    for (int j = 0; j < 32; j++) begin
      if (bb != '0) begin
        if (vv >= rr + bb) begin
          vv = vv - (rr + bb);
          rr = (rr >> 1) + bb;
        end else begin
          rr = rr >> 1;
        end
        bb = bb >> 2;
      end
    end
    return rr;
  endfunction

  function automatic logic [62:0] sat_mag(logic [127:0] v);
    return (v[127:63] != '0) ? MAG_MAX : v[62:0];
  endfunction

  function automatic logic signed [63:0] to_signed(logic [62:0] m, logic neg);
    logic signed [63:0] s;
    s = $signed({1'b0, m});
    return neg ? -s : s;
  endfunction

  function automatic logic [63:0] abs64(logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                 logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s > 65'sd9223372036854775807) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (s < -65'sd9223372036854775807) return 64'sh8000_0000_0000_0001;
    return s[63:0];
  endfunction

endpackage

// File: rtl/cde_mul.sv
// Shared 64x64 unsigned multiplier: one 32x32 partial product per cycle, 128-bit sum.
// Depends on cde_pkg (mul_req_t).
module cde_mul (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cde_pkg::mul_req_t req_i,
  output logic              done_o,
  output logic [127:0]      prod_o
);

  logic [63:0]  a_q, b_q;
  logic [2:0]   cnt_q;
  logic         busy_q, done_q;
  logic [63:0]  pp_q;
  logic [1:0]   sh_q;
  logic [127:0] acc_q;
  logic [31:0]  pa, pb;

  assign pa = cnt_q[1] ? a_q[63:32] : a_q[31:0];
  assign pb = cnt_q[0] ? b_q[63:32] : b_q[31:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !req_i.start && busy_q && (cnt_q == 3'd4);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd4) busy_q <= 1'b0;
      end
    end
  end

  // partial product registered, accumulated in the following cycle
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q   <= req_i.a;
      b_q   <= req_i.b;
      acc_q <= '0;
    end else if (busy_q) begin
      if (cnt_q != 3'd4) begin
        pp_q <= pa * pb;
        sh_q <= {1'b0, cnt_q[1]} + {1'b0, cnt_q[0]};
      end
      if (cnt_q != 3'd0) acc_q <= acc_q + ({64'b0, pp_q} << {sh_q, 5'b0});
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: rtl/cde_div_cell.sv
// One divider cell: eight restoring steps on its dividend byte, remainder to the next cell.
// Depends on cde_pkg (DIV_W).
module cde_div_cell (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      vld_i,
  input  logic [cde_pkg::DIV_W-1:0] rem_i,
  input  logic [7:0]                byte_i,
  input  logic [cde_pkg::DIV_W-1:0] dvs_i,
  output logic                      vld_o,
  output logic [cde_pkg::DIV_W-1:0] rem_o,
  output logic [7:0]                quo_o
);

  logic [cde_pkg::DIV_W:0]   acc;
  logic [cde_pkg::DIV_W-1:0] rem_n;
  logic [7:0]                quo_n;
  logic                      vld_q;
  logic [cde_pkg::DIV_W-1:0] rem_q;
  logic [7:0]                quo_q;

  always_comb begin
    rem_n = rem_i;
    acc   = '0;
    quo_n = '0;
    for (int j = 7; j >= 0; j--) begin
      acc = {rem_n, byte_i[j]};
      if (acc >= {1'b0, dvs_i}) begin
        acc      = acc - {1'b0, dvs_i};
        quo_n[j] = 1'b1;
      end
      rem_n = acc[cde_pkg::DIV_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vld_i) begin
      rem_q <= rem_n;
      quo_q <= quo_n;
    end
  end

  assign vld_o = vld_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// File: rtl/cde_div_chain.sv
// Row of byte cells dividing a 64-bit magnitude by a small divisor, MSB byte first.
// Depends on cde_pkg and cde_div_cell.
module cde_div_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cde_pkg::div_req_t req_i,
  output logic              done_o,
  output logic [63:0]       quot_o
);

  localparam int Cells = cde_pkg::DIV_CELLS;

  logic [8*Cells-1:0]        dvd_q;
  logic [cde_pkg::DIV_W-1:0] dvs_q;
  logic                      go_q;
  logic                      vld [Cells+1];
  logic [cde_pkg::DIV_W-1:0] rem [Cells+1];
  logic [8*Cells-1:0]        quo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      go_q <= 1'b0;
    end else begin
      go_q <= req_i.start;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvd_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end
  end

  assign vld[0] = go_q;
  assign rem[0] = '0;

  for (genvar g = 0; g < Cells; g++) begin : g_cell
    cde_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .vld_i  (vld[g]),
      .rem_i  (rem[g]),
      .byte_i (dvd_q[8*(Cells-1-g) +: 8]),
      .dvs_i  (dvs_q),
      .vld_o  (vld[g+1]),
      .rem_o  (rem[g+1]),
      .quo_o  (quo[8*(Cells-1-g) +: 8])
    );
  end

  assign done_o = vld[Cells];
  assign quot_o = quo;

endmodule

// File: rtl/carrier_density_evaluator.sv
// Carrier density evaluator, top level: sequencer, datapath registers, config and output.
// Both branches sum their series term by term using the 4-pass shared multiplier and
// the 8-cell divider row; one item in flight, next accepted once done.
// Reset (rst_ni, async, active low) clears control and loads register defaults.
// Depends on cde_pkg, cde_mul, cde_div_chain.
module carrier_density_evaluator #(
  parameter int MaxTerms = cde_pkg::MAX_TERMS_DEF,
  parameter int FdTerms  = cde_pkg::FD_TERMS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_addr_i,
  input  logic [47:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         op_i,
  input  logic signed [31:0] fermi_level_i,
  input  logic signed [31:0] band_edge_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] concentration_o,
  output logic               used_polylog_o,
  output logic               range_warning_o,
  output logic               not_converged_o
);

  localparam int KW0 = $clog2(MaxTerms + 1);
  localparam int KW  = (KW0 > cde_pkg::DIV_W) ? KW0 : cde_pkg::DIV_W;
  localparam int IW  = $clog2(MaxTerms);
  localparam logic [63:0] TWO60 = 64'h1000_0000_0000_0000;

  cde_pkg::state_e state_q, state_d;

  logic [31:0] inv_q, tol_q;
  logic [47:0] dos_e_q, dos_h_q;

  logic               holes_q, deriv_q, dneg_q, poly_q, nc_q;
  logic [32:0]        dmag_q;
  logic signed [31:0] r_q;
  logic signed [63:0] sum_q, term_q, e_q, res_q;
  logic [63:0]        t_q;
  logic [62:0]        tmp_mag_q;
  logic               tmp_neg_q;
  logic [3:0]         n_q;
  logic [6:0]         i_q;
  logic [31:0]        ue_q;
  logic [KW-1:0]      k_q;

  logic               out_valid_q, poly_o_q, warn_o_q, nc_o_q;
  logic signed [63:0] conc_q;

  cde_pkg::mul_req_t mul_req;
  cde_pkg::div_req_t div_req;
  logic              mul_done, div_done;
  logic [127:0]      prod;
  logic [63:0]       quot;

  logic [30:0] w_val [MaxTerms];
  logic [30:0] w_der [MaxTerms];

  for (genvar g = 0; g < MaxTerms; g++) begin : g_w
    localparam logic [63:0] KK = 64'(g + 1);
    localparam logic [63:0] QV = TWO60 / (KK * KK * KK);
    localparam logic [63:0] QD = TWO60 / KK;
    localparam logic [63:0] WV = cde_pkg::isqrt64(QV);
    localparam logic [63:0] WD = cde_pkg::isqrt64(QD);
    assign w_val[g] = WV[30:0];
    assign w_der[g] = WD[30:0];
  end

  // input-side gap
  logic signed [32:0] ef, eb, dd;
  assign ef = {fermi_level_i[31], fermi_level_i};
  assign eb = {band_edge_i[31], band_edge_i};
  assign dd = op_i[0] ? ef - eb : eb - ef;

  // reduced energy
  logic [30:0]        q_sat;
  logic signed [31:0] r_new;
  logic               poly_new;
  logic [31:0]        rmag;
  assign q_sat    = (prod[127:55] != '0) ? 31'h7FFF_FFFF : prod[54:24];
  assign r_new    = dneg_q ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
  assign poly_new = holes_q ? (r_new > cde_pkg::R_H_LIMIT) : (r_new > cde_pkg::R_E_LIMIT);
  assign rmag     = r_q[31] ? 32'(-r_q) : 32'(r_q);

  // exp Taylor step
  logic signed [63:0] term_new, e_new;
  assign term_new = cde_pkg::to_signed(quot[62:0], !tmp_neg_q);
  assign e_new    = cde_pkg::sat_add(e_q, term_new);

  logic [60:0] pow_prod;
  assign pow_prod = ue_q * cde_pkg::EINV_Q30;

  // series terms
  logic [KW-1:0]      k_dec;
  logic [IW-1:0]      widx;
  logic [30:0]        w_sel;
  logic               sub;
  logic [4:0]         eta_idx;
  logic signed [63:0] eta_k;
  logic [62:0]        tmag;
  logic               tneg;
  logic [63:0]        bound;
  logic [63:0]        pl_t;
  logic               pl_stop, fd_stop, negate;
  assign k_dec   = k_q - KW'(1);
  assign widx    = k_dec[IW-1:0];
  assign w_sel   = deriv_q ? w_der[widx] : w_val[widx];
  assign sub     = k_q[0] != deriv_q;
  assign eta_idx = k_q[4:0] + {4'b0, deriv_q};
  assign eta_k   = cde_pkg::ETA_Q30[eta_idx];
  assign tmag    = cde_pkg::sat_mag(prod >> 30);
  assign tneg    = eta_k[63] ^ term_q[63];
  assign bound   = prod[95:32];
  assign pl_t    = {30'b0, prod[63:30]};
  assign pl_stop = (t_q == '0) || (t_q < bound);
  assign fd_stop = t_q < bound;
  assign negate  = poly_q ? !(deriv_q && holes_q) : (deriv_q && holes_q);

  logic load_out;
  assign load_out = (state_q == cde_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  cde_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .done_o (mul_done),
    .prod_o (prod)
  );

  cde_div_chain u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .done_o (div_done),
    .quot_o (quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cde_pkg::ST_IDLE:    if (in_valid_i) state_d = cde_pkg::ST_R_GO;
      cde_pkg::ST_R_GO:    state_d = cde_pkg::ST_R_WAIT;
      cde_pkg::ST_R_WAIT: begin
        if (mul_done) state_d = poly_new ? cde_pkg::ST_EM_GO : cde_pkg::ST_FM_GO;
      end
      cde_pkg::ST_EM_GO:   state_d = cde_pkg::ST_EM_WAIT;
      cde_pkg::ST_EM_WAIT: if (mul_done) state_d = cde_pkg::ST_ED_GO;
      cde_pkg::ST_ED_GO:   state_d = cde_pkg::ST_ED_WAIT;
      cde_pkg::ST_ED_WAIT: begin
        if (div_done) begin
          state_d = (n_q == 4'(cde_pkg::EXP_TERMS)) ? cde_pkg::ST_EPOW : cde_pkg::ST_EM_GO;
        end
      end
      cde_pkg::ST_EPOW: begin
        if (i_q == '0 || ue_q == '0) state_d = cde_pkg::ST_PT_GO;
      end
      cde_pkg::ST_PP_GO:   state_d = cde_pkg::ST_PP_WAIT;
      cde_pkg::ST_PP_WAIT: if (mul_done) state_d = cde_pkg::ST_PT_GO;
      cde_pkg::ST_PT_GO:   state_d = cde_pkg::ST_PT_WAIT;
      cde_pkg::ST_PT_WAIT: if (mul_done) state_d = cde_pkg::ST_PB_GO;
      cde_pkg::ST_PB_GO:   state_d = cde_pkg::ST_PB_WAIT;
      cde_pkg::ST_PB_WAIT: begin
        if (mul_done) begin
          if (pl_stop || k_q == KW'(MaxTerms)) begin
            state_d = deriv_q ? cde_pkg::ST_SD_GO : cde_pkg::ST_DOS_GO;
          end else begin
            state_d = cde_pkg::ST_PP_GO;
          end
        end
      end
      cde_pkg::ST_FM_GO:   state_d = cde_pkg::ST_FM_WAIT;
      cde_pkg::ST_FM_WAIT: if (mul_done) state_d = cde_pkg::ST_FD_GO;
      cde_pkg::ST_FD_GO:   state_d = cde_pkg::ST_FD_WAIT;
      cde_pkg::ST_FD_WAIT: if (div_done) state_d = cde_pkg::ST_FT_GO;
      cde_pkg::ST_FT_GO:   state_d = cde_pkg::ST_FT_WAIT;
      cde_pkg::ST_FT_WAIT: if (mul_done) state_d = cde_pkg::ST_FB_GO;
      cde_pkg::ST_FB_GO:   state_d = cde_pkg::ST_FB_WAIT;
      cde_pkg::ST_FB_WAIT: begin
        if (mul_done) begin
          if (fd_stop || k_q == KW'(FdTerms - 1)) begin
            state_d = deriv_q ? cde_pkg::ST_SD_GO : cde_pkg::ST_DOS_GO;
          end else begin
            state_d = cde_pkg::ST_FM_GO;
          end
        end
      end
      cde_pkg::ST_SD_GO:    state_d = cde_pkg::ST_SD_WAIT;
      cde_pkg::ST_SD_WAIT:  if (mul_done) state_d = cde_pkg::ST_DOS_GO;
      cde_pkg::ST_DOS_GO:   state_d = cde_pkg::ST_DOS_WAIT;
      cde_pkg::ST_DOS_WAIT: if (mul_done) state_d = cde_pkg::ST_DONE;
      cde_pkg::ST_DONE:     if (load_out) state_d = cde_pkg::ST_IDLE;
      default:              state_d = cde_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: unit requests and input handshake
  always_comb begin
    mul_req          = '0;
    div_req          = '0;
    div_req.dividend = {1'b0, tmp_mag_q};
    in_ready_o       = 1'b0;
    case (state_q)
      cde_pkg::ST_IDLE:  in_ready_o = 1'b1;
      cde_pkg::ST_R_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = {31'b0, dmag_q};
        mul_req.b     = {32'b0, inv_q};
      end
      cde_pkg::ST_EM_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(term_q);
        mul_req.b     = {34'b0, r_q[23:0], 6'b0};
      end
      cde_pkg::ST_ED_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = {1'b0, n_q};
      end
      cde_pkg::ST_PP_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = term_q;
        mul_req.b     = {32'b0, ue_q};
      end
      cde_pkg::ST_PT_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = term_q;
        mul_req.b     = {33'b0, w_sel};
      end
      cde_pkg::ST_PB_GO, cde_pkg::ST_FB_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(sum_q);
        mul_req.b     = {32'b0, tol_q};
      end
      cde_pkg::ST_FM_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(term_q);
        mul_req.b     = {27'b0, rmag[30:0], 6'b0};
      end
      cde_pkg::ST_FD_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = k_q[cde_pkg::DIV_W-1:0];
      end
      cde_pkg::ST_FT_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(eta_k);
        mul_req.b     = cde_pkg::abs64(term_q);
      end
      cde_pkg::ST_SD_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(sum_q);
        mul_req.b     = {32'b0, inv_q};
      end
      cde_pkg::ST_DOS_GO: begin
        mul_req.start = 1'b1;
        mul_req.a     = cde_pkg::abs64(sum_q);
        mul_req.b     = {16'b0, holes_q ? dos_h_q : dos_e_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cde_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inv_q   <= 32'd648942715;
      dos_e_q <= '0;
      dos_h_q <= '0;
      tol_q   <= 32'd4295;
    end else if (cfg_valid_i) begin
      case (cde_pkg::cfg_idx_e'(cfg_addr_i))
        cde_pkg::CFG_INV:   inv_q   <= cfg_data_i[31:0];
        cde_pkg::CFG_DOS_E: dos_e_q <= cfg_data_i;
        cde_pkg::CFG_DOS_H: dos_h_q <= cfg_data_i;
        cde_pkg::CFG_TOL:   tol_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      cde_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          holes_q <= op_i[0];
          deriv_q <= op_i[1];
          dneg_q  <= dd[32];
          dmag_q  <= dd[32] ? 33'(-dd) : 33'(dd);
        end
      end
      cde_pkg::ST_R_WAIT: begin
        if (mul_done) begin
          r_q    <= r_new;
          poly_q <= poly_new;
          term_q <= cde_pkg::ONE_Q30;
          e_q    <= cde_pkg::ONE_Q30;
          n_q    <= 4'd1;
          k_q    <= KW'(1);
          if (poly_new) sum_q <= '0;
          else sum_q <= deriv_q ? -cde_pkg::ETA_Q30[1] : cde_pkg::ETA_Q30[0];
        end
      end
      cde_pkg::ST_EM_WAIT, cde_pkg::ST_FM_WAIT: begin
        if (mul_done) begin
          tmp_mag_q <= tmag;
          tmp_neg_q <= (state_q == cde_pkg::ST_FM_WAIT) ? (term_q[63] ^ r_q[31]) : term_q[63];
        end
      end
      cde_pkg::ST_ED_WAIT: begin
        if (div_done) begin
          term_q <= term_new;
          e_q    <= e_new;
          n_q    <= n_q + 4'd1;
          i_q    <= r_q[30:24];
          ue_q   <= e_new[63] ? 32'd0 : e_new[31:0];
        end
      end
      cde_pkg::ST_EPOW: begin
        if (i_q != '0 && ue_q != '0) begin
          ue_q <= {1'b0, pow_prod[60:30]};
          i_q  <= i_q - 7'd1;
        end else begin
          term_q <= {32'b0, ue_q};
        end
      end
      cde_pkg::ST_PP_WAIT: if (mul_done) term_q <= pl_t;
      cde_pkg::ST_PT_WAIT: begin
        if (mul_done) begin
          t_q   <= pl_t;
          sum_q <= sub ? sum_q - $signed(pl_t) : sum_q + $signed(pl_t);
        end
      end
      cde_pkg::ST_PB_WAIT: begin
        if (mul_done) begin
          nc_q <= !pl_stop;
          k_q  <= k_q + KW'(1);
        end
      end
      cde_pkg::ST_FD_WAIT: if (div_done) term_q <= cde_pkg::to_signed(quot[62:0], tmp_neg_q);
      cde_pkg::ST_FT_WAIT: begin
        if (mul_done) begin
          t_q   <= {1'b0, tmag};
          sum_q <= cde_pkg::sat_add(sum_q, cde_pkg::to_signed(tmag, tneg ^ sub));
        end
      end
      cde_pkg::ST_FB_WAIT: begin
        if (mul_done) begin
          nc_q <= !fd_stop;
          k_q  <= k_q + KW'(1);
        end
      end
      cde_pkg::ST_SD_WAIT: begin
        if (mul_done) sum_q <= cde_pkg::to_signed(cde_pkg::sat_mag(prod >> 24), sum_q[63]);
      end
      cde_pkg::ST_DOS_WAIT: begin
        if (mul_done) res_q <= cde_pkg::to_signed(cde_pkg::sat_mag(prod), sum_q[63] ^ negate);
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      conc_q   <= res_q;
      poly_o_q <= poly_q;
      warn_o_q <= r_q[31];
      nc_o_q   <= nc_q;
    end
  end

  assign cfg_ready_o     = 1'b1;
  assign out_valid_o     = out_valid_q;
  assign concentration_o = conc_q;
  assign used_polylog_o  = poly_o_q;
  assign range_warning_o = warn_o_q;
  assign not_converged_o = nc_o_q;

`ifndef SYNTHESIS
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == cde_pkg::ST_R_GO)
    else $error("accepted transaction did not start the gap multiply");

  a_mul_done_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> (state_q == cde_pkg::ST_R_WAIT || state_q == cde_pkg::ST_EM_WAIT ||
                  state_q == cde_pkg::ST_PP_WAIT || state_q == cde_pkg::ST_PT_WAIT ||
                  state_q == cde_pkg::ST_PB_WAIT || state_q == cde_pkg::ST_FM_WAIT ||
                  state_q == cde_pkg::ST_FT_WAIT || state_q == cde_pkg::ST_FB_WAIT ||
                  state_q == cde_pkg::ST_SD_WAIT || state_q == cde_pkg::ST_DOS_WAIT))
    else $error("multiplier finished outside a wait state");

  a_polylog_branch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cde_pkg::ST_PT_GO || state_q == cde_pkg::ST_PB_GO) |-> poly_q)
    else $error("polylog step on the Fermi-Dirac branch");

  a_load_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == cde_pkg::ST_DONE))
    else $error("result register loaded outside the done state");
`endif

endmodule
